[sv/source_tokenizer_defines.svh]
// ---------------------------------------------------------------------------
// source_tokenizer_defines
// Assertion macros shared by the tokenizer RTL; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

`ifndef SYNTH
// property checked out of reset
`define ST_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("source_tokenizer: assertion failed");
// property that holds on every edge, reset included
`define ST_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("source_tokenizer: assertion failed");
`else
`define ST_ASSERT(name, clk, rst_n, prop)
`define ST_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[sv/srctok_pkg.sv]
// ---------------------------------------------------------------------------
// srctok_pkg
// Token kinds, character constants, classifiers and the token record.
// ---------------------------------------------------------------------------
package srctok_pkg;

    typedef enum logic [4:0] {
        KIND_EOF     = 5'd0,
        KIND_ERROR   = 5'd1,
        KIND_IDENT   = 5'd2,
        KIND_INT_LIT = 5'd3,
        KIND_FN      = 5'd4,
        KIND_LET     = 5'd5,
        KIND_INT     = 5'd6,
        KIND_PRINT   = 5'd7,
        KIND_PLUS    = 5'd8,
        KIND_MINUS   = 5'd9,
        KIND_STAR    = 5'd10,
        KIND_SLASH   = 5'd11,
        KIND_ASSIGN  = 5'd12,
        KIND_COLON   = 5'd13,
        KIND_SEMI    = 5'd14,
        KIND_LPAREN  = 5'd15,
        KIND_RPAREN  = 5'd16,
        KIND_LBRACE  = 5'd17,
        KIND_RBRACE  = 5'd18
    } kind_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // keyword spellings, first byte in the low bits
    localparam logic [39:0] WORD_FN    = 40'h00_0000_6E66;
    localparam logic [39:0] WORD_LET   = 40'h00_0074_656C;
    localparam logic [39:0] WORD_INT   = 40'h00_0074_6E69;
    localparam logic [39:0] WORD_PRINT = 40'h74_6E69_7270;

    typedef struct packed {
        logic        last;
        logic [15:0] column;
        logic [15:0] line;
        logic [15:0] length;
        logic [15:0] start_offset;
        kind_t       kind;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_word_part(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    // single-byte punctuators; anything else is an error token
    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3D:   k = KIND_ASSIGN;
            8'h3A:   k = KIND_COLON;
            8'h3B:   k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

[sv/source_tokenizer.sv]
// ---------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: one source byte per transfer in, tokens out.
// Tokens are queued at their byte's transfer and offered on m_ from the queue head,
// one per cycle while m_tready is high. Throughput: one byte per cycle; a byte
// closing a pending token may add a second; 4-entry queue, s_tready low above two.
// Reset (aresetn low, synchronous) clears the scan state, counters and queue.
// ---------------------------------------------------------------------------
`include "source_tokenizer_defines.svh"

module source_tokenizer #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [4:0] kind, [20:5] start_offset, [36:21] length,
                                   // [52:37] line, [68:53] column, [71:69] zero
    output logic        m_tlast
);
    import srctok_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_SLASH,
        MODE_COMMENT
    } mode_t;

    localparam int QDEPTH = 4;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [15:0] clip16(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    // scan state
    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] position_reg, position_next;
    logic [COUNT_BITS-1:0] cur_line_reg, cur_line_next;
    logic [COUNT_BITS-1:0] cur_column_reg, cur_column_next;
    logic [COUNT_BITS-1:0] tok_start_reg, tok_start_next;
    logic [COUNT_BITS-1:0] tok_line_reg, tok_line_next;
    logic [COUNT_BITS-1:0] tok_column_reg, tok_column_next;
    logic [COUNT_BITS-1:0] tok_len_reg, tok_len_next;
    logic [39:0]           word_prefix_reg, word_prefix_next;

    // output queue
    token_t     queue_reg [QDEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    logic       s_acc, m_acc;
    logic [7:0] ch;
    logic       emit_a, emit_b;
    token_t     tok_a, tok_b;
    kind_t      word_kind;
    token_t     head;

    assign ch    = s_tdata;
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        if (tok_len_reg == COUNT_BITS'(2) && word_prefix_reg == WORD_FN) begin
            word_kind = KIND_FN;
        end else if (tok_len_reg == COUNT_BITS'(3) && word_prefix_reg == WORD_LET) begin
            word_kind = KIND_LET;
        end else if (tok_len_reg == COUNT_BITS'(3) && word_prefix_reg == WORD_INT) begin
            word_kind = KIND_INT;
        end else if (tok_len_reg == COUNT_BITS'(5) && word_prefix_reg == WORD_PRINT) begin
            word_kind = KIND_PRINT;
        end else begin
            word_kind = KIND_IDENT;
        end
    end

    always_comb begin
        logic held;  // byte absorbed by the pending token or comment
        held             = 1'b0;
        mode_next        = mode_reg;
        position_next    = position_reg;
        cur_line_next    = cur_line_reg;
        cur_column_next  = cur_column_reg;
        tok_start_next   = tok_start_reg;
        tok_line_next    = tok_line_reg;
        tok_column_next  = tok_column_reg;
        tok_len_next     = tok_len_reg;
        word_prefix_next = word_prefix_reg;
        emit_a           = 1'b0;
        emit_b           = 1'b0;
        tok_a            = '0;
        tok_b            = '0;

        // advancing past this byte; overridden where the text ends
        position_next = sat_inc(position_reg);
        if (ch == CH_LF) begin
            cur_line_next   = sat_inc(cur_line_reg);
            cur_column_next = CNT_ONE;
        end else begin
            cur_column_next = sat_inc(cur_column_reg);
        end

        tok_a.start_offset = clip16(tok_start_reg);
        tok_a.line         = clip16(tok_line_reg);
        tok_a.column       = clip16(tok_column_reg);
        tok_a.length       = clip16(tok_len_reg);

        // close or extend the pending token
        case (mode_reg)
            MODE_IDENT: begin
                if (ch != CH_NUL && is_word_part(ch)) begin
                    held = 1'b1;
                end else begin
                    emit_a     = 1'b1;
                    tok_a.kind = word_kind;
                    mode_next  = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                if (is_digit(ch)) begin
                    held = 1'b1;
                end else begin
                    emit_a     = 1'b1;
                    tok_a.kind = KIND_INT_LIT;
                    mode_next  = MODE_IDLE;
                end
            end
            MODE_SLASH: begin
                if (ch == CH_SLASH) begin
                    held      = 1'b1;
                    mode_next = MODE_COMMENT;
                end else begin
                    emit_a       = 1'b1;
                    tok_a.kind   = KIND_SLASH;
                    tok_a.length = 16'd1;
                    mode_next    = MODE_IDLE;
                end
            end
            MODE_COMMENT: begin
                if (ch != CH_NUL) begin
                    held = 1'b1;
                    if (ch == CH_LF) begin
                        mode_next = MODE_IDLE;
                    end
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (held && (mode_reg == MODE_IDENT || mode_reg == MODE_NUM)) begin
            for (int i = 0; i < 5; i++) begin
                if (tok_len_reg == COUNT_BITS'(i)) begin
                    word_prefix_next[8*i +: 8] = ch;
                end
            end
            tok_len_next = sat_inc(tok_len_reg);
        end

        if (!held) begin
            tok_b.start_offset = clip16(position_reg);
            tok_b.line         = clip16(cur_line_reg);
            tok_b.column       = clip16(cur_column_reg);
            tok_b.length       = 16'd1;
            if (ch == CH_NUL) begin
                // end of text: EOF, then everything back to its reset value
                emit_b           = 1'b1;
                tok_b.kind       = KIND_EOF;
                tok_b.length     = 16'd0;
                mode_next        = MODE_IDLE;
                position_next    = '0;
                cur_line_next    = CNT_ONE;
                cur_column_next  = CNT_ONE;
                tok_start_next   = '0;
                tok_line_next    = CNT_ONE;
                tok_column_next  = CNT_ONE;
                tok_len_next     = '0;
                word_prefix_next = '0;
            end else if (is_blank(ch)) begin
                mode_next = MODE_IDLE;
            end else if (ch == CH_SLASH || is_word_start(ch) || is_digit(ch)) begin
                tok_start_next  = position_reg;
                tok_line_next   = cur_line_reg;
                tok_column_next = cur_column_reg;
                if (ch == CH_SLASH) begin
                    tok_len_next     = '0;
                    word_prefix_next = '0;
                    mode_next        = MODE_SLASH;
                end else begin
                    tok_len_next     = CNT_ONE;
                    word_prefix_next = {32'd0, ch};
                    mode_next        = is_digit(ch) ? MODE_NUM : MODE_IDENT;
                end
            end else begin
                emit_b     = 1'b1;
                tok_b.kind = punct_kind(ch);
            end
        end

        tok_a.last = !emit_b;
        tok_b.last = 1'b1;
    end

    // queue bookkeeping
    always_comb begin
        logic [2:0] n_push;
        n_push      = s_acc ? (3'(emit_a) + 3'(emit_b)) : 3'd0;
        wr_ptr_next = wr_ptr_reg + n_push[1:0];
        rd_ptr_next = m_acc ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + n_push - (m_acc ? 3'd1 : 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            position_reg    <= '0;
            cur_line_reg    <= CNT_ONE;
            cur_column_reg  <= CNT_ONE;
            tok_start_reg   <= '0;
            tok_line_reg    <= CNT_ONE;
            tok_column_reg  <= CNT_ONE;
            tok_len_reg     <= '0;
            word_prefix_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end else begin
            if (s_acc) begin
                mode_reg        <= mode_next;
                position_reg    <= position_next;
                cur_line_reg    <= cur_line_next;
                cur_column_reg  <= cur_column_next;
                tok_start_reg   <= tok_start_next;
                tok_line_reg    <= tok_line_next;
                tok_column_reg  <= tok_column_next;
                tok_len_reg     <= tok_len_next;
                word_prefix_reg <= word_prefix_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token payload, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            if (emit_a) begin
                queue_reg[wr_ptr_reg] <= tok_a;
                if (emit_b) begin
                    queue_reg[wr_ptr_reg + 2'd1] <= tok_b;
                end
            end else if (emit_b) begin
                queue_reg[wr_ptr_reg] <= tok_b;
            end
        end
    end

    // room for two tokens is needed before a byte is taken
    assign s_tready = aresetn && (count_reg <= 3'd2);
    assign m_tvalid = aresetn && (count_reg != 3'd0);
    assign head     = queue_reg[rd_ptr_reg];
    assign m_tdata  = {3'b000, head.column, head.line, head.length, head.start_offset,
                       head.kind};
    assign m_tlast  = head.last;

    `ST_ASSERT_ALWAYS(a_idle_in_reset, aclk, !aresetn |-> (!s_tready && !m_tvalid))
    `ST_ASSERT(a_queue_bound, aclk, aresetn, count_reg <= 3'd4)
    `ST_ASSERT(a_eof_clears, aclk, aresetn,
        (s_acc && ch == CH_NUL) |=>
        (position_reg == '0 && mode_reg == MODE_IDLE && tok_len_reg == '0))
    `ST_ASSERT(a_eof_zero_len, aclk, aresetn,
        (m_tvalid && head.kind == KIND_EOF) |-> (head.length == 16'd0 && head.last))
    `ST_ASSERT(a_no_push_when_full, aclk, aresetn,
        (count_reg > 3'd2) |=> (count_reg <= $past(count_reg)))

endmodule
